@@ rtl/core/ppmp6_pkg.sv @@
// Package: shared types and byte constants for the PPM P6 header parser.
`timescale 1ns / 1ps

package ppmp6_pkg;

   // Parser phase
   typedef enum logic [2:0] {
      PH_P      = 3'd0,
      PH_SIX    = 3'd1,
      PH_WIDTH  = 3'd2,
      PH_HEIGHT = 3'd3,
      PH_MAX    = 3'd4,
      PH_PIXEL  = 3'd5,
      PH_ERROR  = 3'd6
   } phase_type;

   // Result kind codes
   typedef enum logic [2:0] {
      K_HEADER  = 3'd0,
      K_DONE    = 3'd1,
      K_PIXEL   = 3'd2,
      K_MAGIC   = 3'd3,
      K_UNSUP   = 3'd4,
      K_INTERR  = 3'd5,
      K_IGNORED = 3'd6
   } kind_type;

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_SIX   = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Header state that does not depend on the value width
   typedef struct packed {
      phase_type   phase;
      logic        in_comment;
      logic        digit_seen;
      logic [15:0] width_val;
      logic [15:0] height_val;
      logic [15:0] max_val;
   } hdr_state_type;

   localparam hdr_state_type HDR_RESET = '{
      phase:      PH_P,
      in_comment: 1'b0,
      digit_seen: 1'b0,
      width_val:  16'd0,
      height_val: 16'd0,
      max_val:    16'd0
   };

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] max_sample;
      logic [7:0]  pixel_value;
      logic        end_of_file;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

endpackage

@@ rtl/core/ppmp6_if.sv @@
// Interfaces: request and response channels of the PPM P6 header parser.
`timescale 1ns / 1ps

interface ppmp6_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppmp6_rsp_if;
   import ppmp6_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [15:0] max_sample;
   logic [7:0]  pixel_value;
   logic        end_of_file;

   modport source (output valid, output kind, output image_width, output image_height,
                   output max_sample, output pixel_value, output end_of_file,
                   input ready);
   modport sink   (input valid, input kind, input image_width, input image_height,
                   input max_sample, input pixel_value, input end_of_file,
                   output ready);
endinterface

@@ rtl/core/ppmp6_step.sv @@
// Step logic: next header state and result for one byte.
`timescale 1ns / 1ps

module ppmp6_step #(
   parameter int VALUE_BITS = 16
) (
   input  ppmp6_pkg::hdr_state_type  cur_state,
   input  logic [VALUE_BITS-1:0]     cur_accum,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output ppmp6_pkg::hdr_state_type  nxt_state,
   output logic [VALUE_BITS-1:0]     nxt_accum,
   output ppmp6_pkg::result_type     result
);
   import ppmp6_pkg::*;

   localparam int EXT_BITS = VALUE_BITS + 4;

   logic [EXT_BITS-1:0]   acc_ext;
   logic [EXT_BITS-1:0]   acc_new;
   logic                  overflow;
   logic                  is_digit;
   logic [31:0]           acc_wide;
   logic [15:0]           acc_low;
   hdr_state_type         upd_state;
   logic [VALUE_BITS-1:0] upd_accum;
   kind_type              kind_raw;
   kind_type              kind_out;

   // Multiply by ten as two shifts and add the digit
   assign acc_ext  = EXT_BITS'(cur_accum);
   assign acc_new  = (acc_ext << 3) + (acc_ext << 1) + EXT_BITS'(data_byte[3:0]);
   assign overflow = |acc_new[EXT_BITS-1:VALUE_BITS];
   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign acc_wide = 32'(cur_accum);
   assign acc_low  = acc_wide[15:0];

   // Advance the parse phase
   always_comb begin
      upd_state = cur_state;
      upd_accum = cur_accum;
      kind_raw  = K_IGNORED;
      case (cur_state.phase)
         PH_P: begin
            if (data_byte == CHAR_P) begin
               upd_state.phase = PH_SIX;
               kind_raw        = K_HEADER;
            end else begin
               upd_state.phase = PH_ERROR;
               kind_raw        = K_MAGIC;
            end
         end
         PH_SIX: begin
            if (data_byte == CHAR_SIX) begin
               upd_state.phase = PH_WIDTH;
               kind_raw        = K_HEADER;
            end else begin
               upd_state.phase = PH_ERROR;
               kind_raw        = K_UNSUP;
            end
         end
         PH_WIDTH, PH_HEIGHT, PH_MAX: begin
            if (cur_state.in_comment) begin
               if ((data_byte == CHAR_CR) || (data_byte == CHAR_LF)) begin
                  upd_state.in_comment = 1'b0;
               end
               kind_raw = K_HEADER;
            end else if (is_digit) begin
               upd_accum = acc_new[VALUE_BITS-1:0];
               if (overflow) begin
                  upd_state.phase = PH_ERROR;
                  kind_raw        = K_INTERR;
               end else begin
                  upd_state.digit_seen = 1'b1;
                  kind_raw             = K_HEADER;
               end
            end else begin
               // Close the integer, then treat the byte as a separator
               if (cur_state.digit_seen) begin
                  upd_accum            = '0;
                  upd_state.digit_seen = 1'b0;
                  if (cur_state.phase == PH_WIDTH) begin
                     upd_state.width_val = acc_low;
                     upd_state.phase     = PH_HEIGHT;
                  end else if (cur_state.phase == PH_HEIGHT) begin
                     upd_state.height_val = acc_low;
                     upd_state.phase      = PH_MAX;
                  end else begin
                     upd_state.max_val = acc_low;
                     upd_state.phase   = PH_PIXEL;
                  end
               end
               if (cur_state.digit_seen && (cur_state.phase == PH_MAX)) begin
                  kind_raw = K_DONE;
               end else if (is_space(data_byte)) begin
                  kind_raw = K_HEADER;
               end else if (data_byte == CHAR_HASH) begin
                  upd_state.in_comment = 1'b1;
                  kind_raw             = K_HEADER;
               end else begin
                  upd_state.phase = PH_ERROR;
                  kind_raw        = K_INTERR;
               end
            end
         end
         PH_PIXEL: begin
            kind_raw = K_PIXEL;
         end
         default: begin
            upd_state.phase = PH_ERROR;
            kind_raw        = K_IGNORED;
         end
      endcase
   end

   // Flag an unfinished header on the last byte
   assign kind_out = (last_byte && (kind_raw == K_HEADER)) ? K_INTERR : kind_raw;

   // Build the result from the updated header state
   always_comb begin
      result.kind         = kind_out;
      result.image_width  = upd_state.width_val;
      result.image_height = upd_state.height_val;
      result.max_sample   = upd_state.max_val;
      result.pixel_value  = (kind_out == K_PIXEL) ? data_byte : 8'd0;
      result.end_of_file  = last_byte;
   end

   // Rearm after the last byte, accumulator included
   assign nxt_state = last_byte ? HDR_RESET : upd_state;
   assign nxt_accum = last_byte ? '0 : upd_accum;

endmodule

@@ rtl/core/ppm_p6_header_parser_unit.sv @@
// Top level: PPM P6 header parser with input and result registers.
//
//   channel | dir | payload                                              | beat
//   req     | in  | data_byte[7:0], last_byte                            | one byte
//   rsp     | out | kind[2:0], image_width/height[15:0], max_sample[15:0],| one result
//           |     | pixel_value[7:0], end_of_file                        |
//
// One byte per cycle sustained while rsp is ready; each accepted byte passes
// through the input register, then the state update into the result register.
// Synchronous active-high reset returns the parser to expecting 'P' and empties
// both registers. A stalled rsp holds the result register; the input register
// then fills and req.ready drops until rsp moves again.
`timescale 1ns / 1ps

module ppm_p6_header_parser_unit #(
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ppmp6_req_if.sink   req,
   ppmp6_rsp_if.source rsp
);
   import ppmp6_pkg::*;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            out_ff;
   hdr_state_type         state_ff;
   logic [VALUE_BITS-1:0] accum_ff;
   hdr_state_type         state_in;
   logic [VALUE_BITS-1:0] accum_in;
   result_type            result;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   // Handshake control
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   ppmp6_step #(
      .VALUE_BITS (VALUE_BITS)
   ) u_step (
      .cur_state (state_ff),
      .cur_accum (accum_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (state_in),
      .nxt_accum (accum_in),
      .result    (result)
   );

   // Control registers and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= HDR_RESET;
         accum_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            accum_ff <= accum_in;
         end
      end
   end

   // Capture the input beat and hold the result beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_ff.kind;
   assign rsp.image_width  = out_ff.image_width;
   assign rsp.image_height = out_ff.image_height;
   assign rsp.max_sample   = out_ff.max_sample;
   assign rsp.pixel_value  = out_ff.pixel_value;
   assign rsp.end_of_file  = out_ff.end_of_file;

endmodule
